// ----- design/rbft_pkg.sv -----
// Package for the receive block filter table: operation codes, result codes,
// tags and the item and result structs. No dependencies.
package rbft_pkg;

  localparam int ENTRIES_DEFAULT = 16;

  localparam logic [2:0] MODE_LISTEN = 3'd0;
  localparam logic [2:0] MODE_SCOUT  = 3'd1;
  localparam logic [2:0] MODE_END    = 3'd2;
  localparam logic [2:0] MODE_ABORT  = 3'd3;
  localparam logic [2:0] MODE_POLL   = 3'd4;
  localparam logic [2:0] MODE_CANCEL = 3'd5;

  localparam logic [2:0] OP_LISTEN = 3'd0;
  localparam logic [2:0] OP_SCOUT  = 3'd1;
  localparam logic [2:0] OP_END    = 3'd2;
  localparam logic [2:0] OP_ABORT  = 3'd3;
  localparam logic [2:0] OP_POLL   = 3'd4;
  localparam logic [2:0] OP_CANCEL = 3'd5;
  localparam logic [2:0] OP_BAD    = 3'd6;

  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_START  = 3'd1;
  localparam logic [2:0] ACT_BCAST  = 3'd2;
  localparam logic [2:0] ACT_CANCEL = 3'd3;
  localparam logic [2:0] ACT_PEEK   = 3'd4;
  localparam logic [2:0] ACT_FINAL  = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_WAITING  = 3'd1;
  localparam logic [2:0] ST_BAD_HND  = 3'd2;
  localparam logic [2:0] ST_BAD_PARM = 3'd3;
  localparam logic [2:0] ST_NO_FREE  = 3'd4;

  localparam logic [7:0]  BCAST_STATION = 8'hff;
  localparam logic [7:0]  MACHINE_PEEK  = 8'h88;
  localparam logic [23:0] RX_TAG        = 24'h567800;
  localparam logic [15:0] TAG_FIELD     = 16'h5678;
  localparam logic [15:0] HDR_BYTES     = 16'd6;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  dest_station;
    logic [15:0] station;
    logic [7:0]  port;
    logic [7:0]  ctrl;
    logic [15:0] length;
    logic [23:0] handle;
    logic [31:0] packet_id;
  } item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  status;
    logic [23:0] out_handle;
    logic [3:0]  entry_index;
    logic [15:0] out_length;
    logic [7:0]  out_ctrl;
    logic [7:0]  out_port;
    logic [15:0] out_station;
    logic [31:0] cancel_id;
  } result_t;

endpackage

// ----- design/receive_block_filter_table.sv -----
// Top level of the receive block filter table: front end, item queue and
// back end. Uses rbft_pkg, rbft_front and rbft_back.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one command beat: listen,
//   scout, data end, receive abort, poll or cancel. Output channel
//   (out_valid / out_stall) returns exactly one result beat per command,
//   in order.
//   An accepted beat passes through a queue slot, the item register, the
//   scan registers (sel, found) and the result register on its way out. The
//   back end works on one beat at a time through fetch, priority scan over the
//   entry table and execute, and fetches no new beat until execute is done.
//   The front end queues two beats, so input keeps flowing while a
//   result waits on a stalled output; once the queue fills, in_stall rises.
//   When out_stall holds, the back end finishes its scan and then waits in
//   its execute step with the table untouched until the result register
//   frees up.
//   Reset (rst, synchronous) empties the queue, drops the output beat,
//   frees every entry and clears the active mark and the saved frame header.
//   Entry contents carry no reset and are only read after a listen.
module receive_block_filter_table_core #(
  parameter int ENTRIES = rbft_pkg::ENTRIES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [7:0]  dest_station,
  input  logic [15:0] station,
  input  logic [7:0]  port,
  input  logic [7:0]  ctrl,
  input  logic [15:0] length,
  input  logic [23:0] handle,
  input  logic [31:0] packet_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  action,
  output logic [2:0]  status,
  output logic [23:0] out_handle,
  output logic [3:0]  entry_index,
  output logic [15:0] out_length,
  output logic [7:0]  out_ctrl,
  output logic [7:0]  out_port,
  output logic [15:0] out_station,
  output logic [31:0] cancel_id
);

  logic              q_valid;
  logic              q_pop;
  rbft_pkg::item_t   q_item;
  rbft_pkg::result_t res;

  rbft_front u_front (
    .clk, .rst, .in_valid, .in_stall, .mode, .dest_station, .station, .port,
    .ctrl, .length, .handle, .packet_id, .q_valid, .q_item, .q_pop
  );

  rbft_back #(.ENTRIES(ENTRIES)) u_back (
    .clk, .rst, .q_valid, .q_item, .q_pop, .out_valid, .out_stall, .res
  );

  assign action      = res.action;
  assign status      = res.status;
  assign out_handle  = res.out_handle;
  assign entry_index = res.entry_index;
  assign out_length  = res.out_length;
  assign out_ctrl    = res.out_ctrl;
  assign out_port    = res.out_port;
  assign out_station = res.out_station;
  assign cancel_id   = res.cancel_id;

  // A transaction id is only reported for a cancel order.
  a_cancel_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && action != rbft_pkg::ACT_CANCEL |-> cancel_id == 32'd0)
    else $error("cancel_id set without cancel action");

  // A receive start always reports ok status.
  a_start_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == rbft_pkg::ACT_START |-> status == rbft_pkg::ST_OK)
    else $error("start with error status");

  // A listen handle comes only with ok status and no action.
  a_handle_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_handle != 24'd0 |->
      status == rbft_pkg::ST_OK && action == rbft_pkg::ACT_NONE)
    else $error("handle returned with error or action");

endmodule

// ----- design/rbft_front.sv -----
// Front end: accepts input beats, decodes the mode into an operation code
// and holds up to two items for the back end. Uses rbft_pkg.
module rbft_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          mode,
  input  logic [7:0]          dest_station,
  input  logic [15:0]         station,
  input  logic [7:0]          port,
  input  logic [7:0]          ctrl,
  input  logic [15:0]         length,
  input  logic [23:0]         handle,
  input  logic [31:0]         packet_id,
  output logic                q_valid,
  output rbft_pkg::item_t     q_item,
  input  logic                q_pop
);

  rbft_pkg::item_t slots [2];
  logic            wptr;
  logic            rptr;
  logic [1:0]      count;
  logic            push;
  logic [2:0]      op_dec;

  always_comb begin
    unique case (mode)
      rbft_pkg::MODE_LISTEN: op_dec = rbft_pkg::OP_LISTEN;
      rbft_pkg::MODE_SCOUT:  op_dec = rbft_pkg::OP_SCOUT;
      rbft_pkg::MODE_END:    op_dec = rbft_pkg::OP_END;
      rbft_pkg::MODE_ABORT:  op_dec = rbft_pkg::OP_ABORT;
      rbft_pkg::MODE_POLL:   op_dec = rbft_pkg::OP_POLL;
      rbft_pkg::MODE_CANCEL: op_dec = rbft_pkg::OP_CANCEL;
      default:               op_dec = rbft_pkg::OP_BAD;
    endcase
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= '{op: op_dec, dest_station: dest_station, station: station,
                       port: port, ctrl: ctrl, length: length, handle: handle,
                       packet_id: packet_id};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ----- design/rbft_back.sv -----
// Back end: entry table, priority scan and execution of one item, with a
// result register toward the output channel. Uses rbft_pkg.
module rbft_back #(
  parameter int ENTRIES = rbft_pkg::ENTRIES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  rbft_pkg::item_t     q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output rbft_pkg::result_t   res
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]      state;
  rbft_pkg::item_t it;

  logic [ENTRIES-1:0] entry_used;
  logic [7:0]         entry_ctrl    [ENTRIES];
  logic [7:0]         entry_port    [ENTRIES];
  logic [15:0]        entry_station [ENTRIES];
  logic [15:0]        entry_length  [ENTRIES];

  logic          active_valid;
  logic [IW-1:0] active_entry;
  logic [7:0]    saved_ctrl;
  logic [7:0]    saved_port;
  logic [15:0]   saved_station;

  logic [IW-1:0] sel;
  logic          found;
  logic [IW-1:0] scan_idx;
  logic          scan_found;
  logic [IW-1:0] hslot;
  logic          hin_range;

  logic [ENTRIES-1:0] cand;
  logic               can_out;
  logic               tag_ok;
  logic [15:0]        sel_len;
  logic [15:0]        body_len;
  logic [15:0]        clip_len;
  rbft_pkg::result_t  r;

  assign hslot     = it.handle[IW-1:0];
  assign hin_range = ({1'b0, it.handle[7:0]} < 9'(ENTRIES));
  assign tag_ok    = (it.handle[23:8] == rbft_pkg::TAG_FIELD);

  // Candidate vector: free entries for listen, open and matching for scout.
  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      if (it.op == rbft_pkg::OP_LISTEN) begin
        cand[k] = !entry_used[k];
      end else begin
        cand[k] = entry_used[k] && (entry_ctrl[k] == 8'd0) &&
                  (entry_port[k] == 8'd0 || entry_port[k] == it.port) &&
                  (entry_station[k] == 16'd0 || entry_station[k] == it.station);
      end
    end
  end

  always_comb begin
    scan_idx   = '0;
    scan_found = 1'b0;
    for (int k = ENTRIES - 1; k >= 0; k--) begin
      if (cand[k]) begin
        scan_idx   = IW'(k);
        scan_found = 1'b1;
      end
    end
  end

  assign can_out  = !out_valid || !out_stall;
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign sel_len  = entry_length[sel];
  assign body_len = it.length - rbft_pkg::HDR_BYTES;
  assign clip_len = (it.length >= rbft_pkg::HDR_BYTES && body_len < sel_len) ?
                    body_len : sel_len;

  always_comb begin
    r = '0;
    case (it.op)
      rbft_pkg::OP_LISTEN: begin
        if (it.ctrl != 8'd0) r.status = rbft_pkg::ST_BAD_PARM;
        else if (!found) r.status = rbft_pkg::ST_NO_FREE;
        else r.out_handle = rbft_pkg::RX_TAG | 24'(sel);
      end
      rbft_pkg::OP_SCOUT: begin
        if (it.port != 8'd0) begin
          if (found) begin
            r.entry_index = 4'(sel);
            if (it.dest_station == rbft_pkg::BCAST_STATION) begin
              r.action = rbft_pkg::ACT_BCAST;
            end else begin
              r.action     = rbft_pkg::ACT_START;
              r.out_length = sel_len;
            end
          end else if (it.dest_station != rbft_pkg::BCAST_STATION) begin
            r.action    = rbft_pkg::ACT_CANCEL;
            r.cancel_id = it.packet_id;
          end
        end else if (it.dest_station != rbft_pkg::BCAST_STATION) begin
          if (it.ctrl == rbft_pkg::MACHINE_PEEK) begin
            r.action = rbft_pkg::ACT_PEEK;
          end else begin
            r.action    = rbft_pkg::ACT_CANCEL;
            r.cancel_id = it.packet_id;
          end
        end
      end
      rbft_pkg::OP_END: begin
        r.action = rbft_pkg::ACT_FINAL;
        if (active_valid) r.entry_index = 4'(active_entry);
      end
      rbft_pkg::OP_ABORT: begin
      end
      rbft_pkg::OP_POLL, rbft_pkg::OP_CANCEL: begin
        if (!tag_ok) begin
          r.status = rbft_pkg::ST_BAD_HND;
        end else begin
          r.entry_index = it.handle[3:0];
          if (!hin_range || !entry_used[sel]) begin
            r.status = (it.op == rbft_pkg::OP_POLL) ? rbft_pkg::ST_BAD_HND :
                       rbft_pkg::ST_BAD_PARM;
          end else if (it.op == rbft_pkg::OP_POLL) begin
            if (entry_ctrl[sel] == 8'd0) begin
              r.status = rbft_pkg::ST_WAITING;
            end else begin
              r.out_length  = sel_len;
              r.out_ctrl    = entry_ctrl[sel];
              r.out_port    = entry_port[sel];
              r.out_station = entry_station[sel];
            end
          end
        end
      end
      default: r.status = rbft_pkg::ST_BAD_PARM;
    endcase
  end

  // Table payload: written only in the execute step.
  always_ff @(posedge clk) begin
    if (state == S_EXEC && can_out) begin
      case (it.op)
        rbft_pkg::OP_LISTEN: begin
          if (it.ctrl == 8'd0 && found) begin
            entry_ctrl[sel]    <= 8'd0;
            entry_port[sel]    <= it.port;
            entry_station[sel] <= it.station;
            entry_length[sel]  <= it.length;
          end
        end
        rbft_pkg::OP_SCOUT: begin
          if (it.port != 8'd0 && found &&
              it.dest_station == rbft_pkg::BCAST_STATION) begin
            entry_ctrl[sel]    <= it.ctrl;
            entry_port[sel]    <= it.port;
            entry_station[sel] <= it.station;
            entry_length[sel]  <= clip_len;
          end
        end
        rbft_pkg::OP_END: begin
          if (active_valid) begin
            entry_ctrl[active_entry]    <= saved_ctrl;
            entry_port[active_entry]    <= saved_port;
            entry_station[active_entry] <= saved_station;
            entry_length[active_entry]  <= it.length;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) it <= q_item;
    if (state == S_SCAN) begin
      if (it.op == rbft_pkg::OP_POLL || it.op == rbft_pkg::OP_CANCEL) begin
        sel   <= hslot;
        found <= hin_range;
      end else begin
        sel   <= scan_idx;
        found <= scan_found;
      end
    end
    if (state == S_EXEC && can_out) res <= r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      entry_used    <= '0;
      active_valid  <= 1'b0;
      active_entry  <= '0;
      saved_ctrl    <= '0;
      saved_port    <= '0;
      saved_station <= '0;
    end else begin
      // Held while stalled, loaded on the execute step.
      out_valid <= (out_valid && out_stall) || (state == S_EXEC && can_out);
      unique case (state)
        S_IDLE: if (q_valid) state <= S_SCAN;
        S_SCAN: state <= S_EXEC;
        S_EXEC: begin
          if (can_out) begin
            state <= S_IDLE;
            case (it.op)
              rbft_pkg::OP_LISTEN: begin
                if (it.ctrl == 8'd0 && found) entry_used[sel] <= 1'b1;
              end
              rbft_pkg::OP_SCOUT: begin
                if (it.port != 8'd0) begin
                  saved_ctrl    <= it.ctrl;
                  saved_port    <= it.port;
                  saved_station <= it.station;
                end
                if (it.port != 8'd0 && found &&
                    it.dest_station != rbft_pkg::BCAST_STATION) begin
                  active_valid <= 1'b1;
                  active_entry <= sel;
                end
              end
              rbft_pkg::OP_ABORT: active_valid <= 1'b0;
              rbft_pkg::OP_POLL: begin
                if (tag_ok && found && entry_used[sel] && entry_ctrl[sel] != 8'd0)
                  entry_used[sel] <= 1'b0;
              end
              rbft_pkg::OP_CANCEL: begin
                if (tag_ok && found) entry_used[sel] <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- bench/tb.sv -----
// Testbench for receive_block_filter_table_core: a queue-fed driver, a stall
// pattern on the output, and a predictor of the entry table that checks every
// result beat field by field. Depends on rbft_pkg and the RTL.
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ENTRIES = 16;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  mode;
  logic [7:0]  dest_station;
  logic [15:0] station;
  logic [7:0]  port;
  logic [7:0]  ctrl;
  logic [15:0] length;
  logic [23:0] handle;
  logic [31:0] packet_id;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  action;
  logic [2:0]  status;
  logic [23:0] out_handle;
  logic [3:0]  entry_index;
  logic [15:0] out_length;
  logic [7:0]  out_ctrl;
  logic [7:0]  out_port;
  logic [15:0] out_station;
  logic [31:0] cancel_id;

  receive_block_filter_table_core #(.ENTRIES(NUM_ENTRIES)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .dest_station(dest_station), .station(station), .port(port),
    .ctrl(ctrl), .length(length), .handle(handle), .packet_id(packet_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .action(action), .status(status), .out_handle(out_handle),
    .entry_index(entry_index), .out_length(out_length), .out_ctrl(out_ctrl),
    .out_port(out_port), .out_station(out_station), .cancel_id(cancel_id)
  );

  // Predictor copy of the table. Entry contents are only read for used entries.
  logic        tbl_used    [NUM_ENTRIES];
  logic [7:0]  tbl_ctrl    [NUM_ENTRIES];
  logic [7:0]  tbl_port    [NUM_ENTRIES];
  logic [15:0] tbl_station [NUM_ENTRIES];
  logic [15:0] tbl_length  [NUM_ENTRIES];
  logic        act_valid;
  logic [3:0]  act_entry;
  logic [7:0]  hdr_ctrl;
  logic [7:0]  hdr_port;
  logic [15:0] hdr_station;

  rbft_pkg::item_t   pending_beats[$];
  rbft_pkg::result_t expected_results[$];
  int      mismatches = 0;
  int      beats_sent = 0;
  int      results_seen = 0;
  int      cycle_count = 0;
  bit      stimulus_done;

  // Work out the single result a command produces and update the table copy.
  function automatic rbft_pkg::result_t filter_table_step(rbft_pkg::item_t it);
    rbft_pkg::result_t r;
    int      i;
    int      hit;
    logic [15:0] d;
    r = '0;
    case (it.op)
      rbft_pkg::MODE_LISTEN: begin
        if (it.ctrl != 8'd0) begin
          r.status = rbft_pkg::ST_BAD_PARM;
        end else begin
          hit = -1;
          for (i = 0; i < NUM_ENTRIES; i++)
            if (hit < 0 && !tbl_used[i]) hit = i;
          if (hit < 0) begin
            r.status = rbft_pkg::ST_NO_FREE;
          end else begin
            tbl_used[hit]    = 1'b1;
            tbl_ctrl[hit]    = 8'd0;
            tbl_port[hit]    = it.port;
            tbl_station[hit] = it.station;
            tbl_length[hit]  = it.length;
            r.out_handle     = rbft_pkg::RX_TAG | 24'(hit);
          end
        end
      end
      rbft_pkg::MODE_SCOUT: begin
        if (it.port != 8'd0) begin
          hdr_ctrl    = it.ctrl;
          hdr_port    = it.port;
          hdr_station = it.station;
          hit = -1;
          for (i = 0; i < NUM_ENTRIES; i++)
            if (hit < 0 && tbl_used[i] && tbl_ctrl[i] == 8'd0 &&
                (tbl_port[i] == 8'd0 || tbl_port[i] == hdr_port) &&
                (tbl_station[i] == 16'd0 || tbl_station[i] == hdr_station))
              hit = i;
          if (hit >= 0) begin
            r.entry_index = 4'(hit);
            if (it.dest_station == rbft_pkg::BCAST_STATION) begin
              d = tbl_length[hit];
              if (it.length >= rbft_pkg::HDR_BYTES && (it.length - rbft_pkg::HDR_BYTES) < d)
                d = it.length - rbft_pkg::HDR_BYTES;
              tbl_length[hit]  = d;
              tbl_ctrl[hit]    = hdr_ctrl;
              tbl_port[hit]    = hdr_port;
              tbl_station[hit] = hdr_station;
              r.action = rbft_pkg::ACT_BCAST;
            end else begin
              act_valid    = 1'b1;
              act_entry    = 4'(hit);
              r.action     = rbft_pkg::ACT_START;
              r.out_length = tbl_length[hit];
            end
          end else if (it.dest_station != rbft_pkg::BCAST_STATION) begin
            r.action    = rbft_pkg::ACT_CANCEL;
            r.cancel_id = it.packet_id;
          end
        end else if (it.dest_station != rbft_pkg::BCAST_STATION) begin
          if (it.ctrl == rbft_pkg::MACHINE_PEEK) begin
            r.action = rbft_pkg::ACT_PEEK;
          end else begin
            r.action    = rbft_pkg::ACT_CANCEL;
            r.cancel_id = it.packet_id;
          end
        end
      end
      rbft_pkg::MODE_END: begin
        if (act_valid) begin
          tbl_length[act_entry]  = it.length;
          tbl_ctrl[act_entry]    = hdr_ctrl;
          tbl_port[act_entry]    = hdr_port;
          tbl_station[act_entry] = hdr_station;
          r.entry_index = act_entry;
        end
        r.action = rbft_pkg::ACT_FINAL;
      end
      rbft_pkg::MODE_ABORT: act_valid = 1'b0;
      rbft_pkg::MODE_POLL, rbft_pkg::MODE_CANCEL: begin
        if (it.handle[23:8] != rbft_pkg::TAG_FIELD) begin
          r.status = rbft_pkg::ST_BAD_HND;
        end else begin
          r.entry_index = it.handle[3:0];
          i = it.handle[7:0];
          if (i >= NUM_ENTRIES || !tbl_used[i]) begin
            r.status = (it.op == rbft_pkg::MODE_POLL) ? rbft_pkg::ST_BAD_HND :
                       rbft_pkg::ST_BAD_PARM;
          end else if (it.op == rbft_pkg::MODE_CANCEL) begin
            tbl_used[i] = 1'b0;
          end else if (tbl_ctrl[i] == 8'd0) begin
            r.status = rbft_pkg::ST_WAITING;
          end else begin
            r.out_length  = tbl_length[i];
            r.out_ctrl    = tbl_ctrl[i];
            r.out_port    = tbl_port[i];
            r.out_station = tbl_station[i];
            tbl_used[i]   = 1'b0;
          end
        end
      end
      default: r.status = rbft_pkg::ST_BAD_PARM;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
    mismatches++;
  endtask

  // Random beat with every field fully random.
  function automatic rbft_pkg::item_t noise_beat();
    rbft_pkg::item_t it;
    it.op           = 3'($urandom_range(0, 7));
    it.dest_station = 8'($urandom);
    it.station      = 16'($urandom);
    it.port         = 8'($urandom);
    it.ctrl         = 8'($urandom);
    it.length       = 16'($urandom);
    it.handle       = 24'($urandom);
    it.packet_id    = $urandom;
    return it;
  endfunction

  // Beat with small filter values so listens and scouts meet often.
  function automatic rbft_pkg::item_t likely_beat(logic [2:0] op);
    rbft_pkg::item_t it;
    it = noise_beat();
    it.op           = op;
    it.ctrl         = ($urandom_range(0, 3) != 0) ? 8'd0 : 8'($urandom);
    it.port         = 8'($urandom_range(0, 3));
    it.station      = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    it.dest_station = ($urandom_range(0, 2) == 0) ? rbft_pkg::BCAST_STATION : 8'($urandom);
    it.length       = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
    if (op == rbft_pkg::MODE_SCOUT && it.port == 8'd0 && $urandom_range(0, 1))
      it.ctrl = rbft_pkg::MACHINE_PEEK;
    if ($urandom_range(0, 7) != 0)
      it.handle = {rbft_pkg::TAG_FIELD, 8'($urandom_range(0, NUM_ENTRIES - 1))};
    else if ($urandom_range(0, 1))
      it.handle = {rbft_pkg::TAG_FIELD, 8'($urandom)};
    return it;
  endfunction

  function automatic rbft_pkg::item_t directed_beat(logic [2:0] op, logic [7:0] dst,
                                                    logic [15:0] stn, logic [7:0] prt,
                                                    logic [7:0] ctl, logic [15:0] len,
                                                    logic [23:0] hnd, logic [31:0] pid);
    rbft_pkg::item_t it;
    it = '{op, dst, stn, prt, ctl, len, hnd, pid};
    return it;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stimulus: directed corners, then random work weighted toward live sequences.
  initial begin
    int   n;
    int   pick;
    stimulus_done = 1'b0;
    pending_beats.push_back(directed_beat(rbft_pkg::MODE_END, 8'h00, 16'h0000, 8'h00, 8'h00,
                                          16'h0000, 24'h0, 32'h0));          // end, none active
    pending_beats.push_back(directed_beat(rbft_pkg::MODE_LISTEN, 8'h00, 16'h0000, 8'h05, 8'h01,
                                          16'd10, 24'h0, 32'h0));            // bad ctrl
    pending_beats.push_back(directed_beat(rbft_pkg::MODE_LISTEN, 8'h00, 16'h0000, 8'h00, 8'h00,
                                          16'hffff, 24'h0, 32'h0));          // wildcard
    pending_beats.push_back(directed_beat(rbft_pkg::MODE_LISTEN, 8'h00, 16'hffff, 8'hff, 8'h00,
                                          16'd0, 24'h0, 32'h0));
    pending_beats.push_back(directed_beat(rbft_pkg::MODE_SCOUT, 8'hff, 16'h1234, 8'h07, 8'h80,
                                          16'd3, 24'h0, 32'h1));             // short bcast
    pending_beats.push_back(directed_beat(rbft_pkg::MODE_SCOUT, 8'hff, 16'hffff, 8'hff, 8'hff,
                                          16'hffff, 24'h0, 32'h2));
    pending_beats.push_back(directed_beat(rbft_pkg::MODE_SCOUT, 8'hff, 16'h1, 8'h3, 8'h1,
                                          16'd20, 24'h0, 32'h3));            // bcast, no match
    pending_beats.push_back(directed_beat(rbft_pkg::MODE_SCOUT, 8'h01, 16'h1, 8'h3, 8'h1,
                                          16'd20, 24'h0, 32'hffffffff));     // no match, cancel
    pending_beats.push_back(directed_beat(rbft_pkg::MODE_SCOUT, 8'h01, 16'h1, 8'h00,
                                          rbft_pkg::MACHINE_PEEK,
                                          16'd0, 24'h0, 32'h5));             // peek
    pending_beats.push_back(directed_beat(rbft_pkg::MODE_SCOUT, 8'h01, 16'h1, 8'h00, 8'h81,
                                          16'd0, 24'h0, 32'hdeadbeef));      // immediate cancel
    pending_beats.push_back(directed_beat(rbft_pkg::MODE_SCOUT, 8'hff, 16'h1, 8'h00,
                                          rbft_pkg::MACHINE_PEEK,
                                          16'd0, 24'h0, 32'h6));             // bcast immediate
    pending_beats.push_back(directed_beat(rbft_pkg::MODE_POLL, 8'h0, 16'h0, 8'h0, 8'h0, 16'h0,
                                          24'h567800, 32'h0));               // complete
    pending_beats.push_back(directed_beat(rbft_pkg::MODE_POLL, 8'h0, 16'h0, 8'h0, 8'h0, 16'h0,
                                          24'h567801, 32'h0));
    pending_beats.push_back(directed_beat(rbft_pkg::MODE_POLL, 8'h0, 16'h0, 8'h0, 8'h0, 16'h0,
                                          24'h567800, 32'h0));               // freed entry
    pending_beats.push_back(directed_beat(rbft_pkg::MODE_CANCEL, 8'h0, 16'h0, 8'h0, 8'h0, 16'h0,
                                          24'h5678ff, 32'h0));               // index too big
    pending_beats.push_back(directed_beat(rbft_pkg::MODE_POLL, 8'h0, 16'h0, 8'h0, 8'h0, 16'h0,
                                          24'hffffff, 32'h0));               // bad tag
    pending_beats.push_back(directed_beat(rbft_pkg::MODE_LISTEN, 8'h0, 16'h0, 8'h0, 8'h0,
                                          16'd50, 24'h0, 32'h0));
    pending_beats.push_back(directed_beat(rbft_pkg::MODE_SCOUT, 8'h02, 16'h42, 8'h09, 8'h11,
                                          16'd30, 24'h0, 32'h7));            // start
    pending_beats.push_back(directed_beat(rbft_pkg::MODE_POLL, 8'h0, 16'h0, 8'h0, 8'h0, 16'h0,
                                          24'h567800, 32'h0));               // waiting
    pending_beats.push_back(directed_beat(rbft_pkg::MODE_END, 8'h0, 16'h0, 8'h0, 8'h0, 16'd25,
                                          24'h0, 32'h0));
    pending_beats.push_back(directed_beat(rbft_pkg::MODE_ABORT, 8'h0, 16'h0, 8'h0, 8'h0, 16'h0,
                                          24'h0, 32'h0));
    pending_beats.push_back(directed_beat(3'd6, 8'h0, 16'h0, 8'h0, 8'h0, 16'h0, 24'h0, 32'h0));
    pending_beats.push_back(directed_beat(3'd7, 8'h0, 16'h0, 8'h0, 8'h0, 16'h0, 24'h0, 32'h0));
    for (n = 0; n < NUM_ENTRIES + 1; n++)                                    // fill table
      pending_beats.push_back(directed_beat(rbft_pkg::MODE_LISTEN, 8'h0, 16'h0, 8'h0, 8'h0,
                                            16'd8, 24'h0, 32'h0));
    for (n = 0; n < NUM_ENTRIES; n++)
      pending_beats.push_back(directed_beat(rbft_pkg::MODE_CANCEL, 8'h0, 16'h0, 8'h0, 8'h0,
                                            16'h0, {rbft_pkg::TAG_FIELD, 8'(n)}, 32'h0));
    // Random part: mostly listen/scout/end/poll traffic, some pure noise.
    for (n = 0; n < 1900; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8)       pending_beats.push_back(noise_beat());
      else if (pick < 28) pending_beats.push_back(likely_beat(rbft_pkg::MODE_LISTEN));
      else if (pick < 58) pending_beats.push_back(likely_beat(rbft_pkg::MODE_SCOUT));
      else if (pick < 68) pending_beats.push_back(likely_beat(rbft_pkg::MODE_END));
      else if (pick < 74) pending_beats.push_back(likely_beat(rbft_pkg::MODE_ABORT));
      else if (pick < 90) pending_beats.push_back(likely_beat(rbft_pkg::MODE_POLL));
      else                pending_beats.push_back(likely_beat(rbft_pkg::MODE_CANCEL));
    end
    stimulus_done = 1'b1;
  end

  // Driver: bursts of beats separated by random gaps. A payload holds while stalled.
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    rbft_pkg::item_t nx;
    if (rst) begin
      in_valid     <= 1'b0;
      mode         <= rbft_pkg::MODE_ABORT;
      dest_station <= 8'd0;
      station      <= 16'd0;
      port         <= 8'd0;
      ctrl         <= 8'd0;
      length       <= 16'd0;
      handle       <= 24'd0;
      packet_id    <= 32'd0;
      burst_left   <= $urandom_range(1, 12);
      gap_left     <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) beats_sent <= beats_sent + 1;
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        nx = pending_beats.pop_front();
        expected_results.push_back(filter_table_step(nx));
        in_valid     <= 1'b1;
        mode         <= nx.op;
        dest_station <= nx.dest_station;
        station      <= nx.station;
        port         <= nx.port;
        ctrl         <= nx.ctrl;
        length       <= nx.length;
        handle       <= nx.handle;
        packet_id    <= nx.packet_id;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: alternates quiet stretches with random stalling.
  int stall_phase;
  always @(posedge clk) begin
    if (rst) begin
      out_stall   <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= (stall_phase + 1) % 300;
      if (stall_phase < 100) out_stall <= 1'b0;
      else if (stall_phase < 200) out_stall <= ($urandom_range(0, 3) == 0);
      else out_stall <= ($urandom_range(0, 1) == 0);
    end
  end

  // Monitor: compare each accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    rbft_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat", action, 0);
      end else begin
        want = expected_results.pop_front();
        if (action !== want.action) report_mismatch("action", action, want.action);
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (out_handle !== want.out_handle)
          report_mismatch("out_handle", out_handle, want.out_handle);
        if (entry_index !== want.entry_index)
          report_mismatch("entry_index", entry_index, want.entry_index);
        if (out_length !== want.out_length)
          report_mismatch("out_length", out_length, want.out_length);
        if (out_ctrl !== want.out_ctrl) report_mismatch("out_ctrl", out_ctrl, want.out_ctrl);
        if (out_port !== want.out_port) report_mismatch("out_port", out_port, want.out_port);
        if (out_station !== want.out_station)
          report_mismatch("out_station", out_station, want.out_station);
        if (cancel_id !== want.cancel_id)
          report_mismatch("cancel_id", cancel_id, want.cancel_id);
      end
      results_seen <= results_seen + 1;
    end
  end

  // Reset, run control and the final verdict.
  initial begin
    int i;
    for (i = 0; i < NUM_ENTRIES; i++) begin
      tbl_used[i] = 1'b0;
      tbl_ctrl[i] = 8'd0;
      tbl_port[i] = 8'd0;
      tbl_station[i] = 16'd0;
      tbl_length[i] = 16'd0;
    end
    act_valid = 1'b0;
    act_entry = 4'd0;
    hdr_ctrl = 8'd0;
    hdr_port = 8'd0;
    hdr_station = 16'd0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (!(stimulus_done && pending_beats.size() == 0 && !in_valid &&
             expected_results.size() == 0) && cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("FAILED: results differ");
    end else begin
      repeat (20) @(posedge clk);
      $display("Ran %0d command beats through the table, %0d result beats checked.",
               beats_sent, results_seen);
      $display("Mixed listen/scout/end/abort/poll/cancel traffic with random stalls.");
      if (mismatches == 0 && expected_results.size() == 0)
        $display("PASSED: all results match");
      else
        $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
